/* hdl/rotated_sorted_search_dup_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the rotated sorted search core
// Clocked checks that are disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef ROTATED_SORTED_SEARCH_DUP_CORE_ASSERT_SVH
`define ROTATED_SORTED_SEARCH_DUP_CORE_ASSERT_SVH

// A property that must hold at every clock edge.
`define RSSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RSSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rssd_pkg.sv */
// ---------------------------------------------------------------------------
// Rotated sorted search package
// Sizes, action codes and request and response types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rssd_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int PTR_W        = CNT_W + 1;
    localparam int DATA_W       = 32;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_FULL   = 1'b1;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic result_kind;
        logic found;
    } t_rsp;

endpackage

/* hdl/rotated_sorted_search_dup_core.sv */
// ---------------------------------------------------------------------------
// Rotated sorted search core
// Stores appended words and searches them as a rotated nondecreasing array.
// ---------------------------------------------------------------------------
// Clear requests and appends with room finish in S_IDLE without a stall. An
// append to a full store goes on to S_EMIT to load its response. A search
// request holds off the next request while it passes through S_RD1, S_RD2
// and S_EVAL for each search step and then S_EMIT, with a last S_RD1 before
// S_EMIT when the target is not found. The next request is taken once the
// core is back in S_IDLE. Each step reads the low, middle and high entries
// from the element memory, which has two read ports with registered outputs.
// A search takes about log2 of the element count steps. When runs of equal
// entries force both bounds in by one, it takes up to half the element
// count plus one steps. A response waits in S_EMIT while the output stalls.
`timescale 1ns / 1ps

module rotated_sorted_search_dup_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  rssd_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output rssd_pkg::t_rsp o_rsp
);
    import rssd_pkg::*;

    `include "rotated_sorted_search_dup_core_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EVAL,
        S_EMIT
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [PTR_W-1:0]  r_lo, n_lo;
    logic signed [PTR_W-1:0]  r_hi, n_hi;
    logic signed [PTR_W-1:0]  r_mid, n_mid;
    logic signed [DATA_W-1:0] r_target, n_target;
    logic signed [DATA_W-1:0] r_vl, n_vl;
    logic signed [DATA_W-1:0] r_vh, n_vh;
    t_rsp                     r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    t_rsp                     r_out, n_out;

    logic signed [DATA_W-1:0] r_mem [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] r_rd_a;
    logic signed [DATA_W-1:0] r_rd_b;
    logic                     w_we;
    logic [IDX_W-1:0]         w_wa;
    logic [IDX_W-1:0]         w_ra_a;
    logic [IDX_W-1:0]         w_ra_b;
    logic [PTR_W:0]           w_sum;
    logic signed [DATA_W-1:0] w_vm;
    logic                     w_accept;
    logic                     w_emit_load;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
    assign w_accept    = i_req_valid && !o_req_stall;
    assign w_sum       = {r_lo[PTR_W-1], r_lo} + {r_hi[PTR_W-1], r_hi};
    assign w_vm        = r_rd_a;
    assign w_emit_load = (r_state == S_EMIT) && (!r_out_valid || !i_rsp_stall);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= i_req.value;
        end
        r_rd_a <= r_mem[w_ra_a];
        r_rd_b <= r_mem[w_ra_b];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_target    = r_target;
        n_vl        = r_vl;
        n_vh        = r_vh;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_wa        = r_count[IDX_W-1:0];
        w_ra_a      = r_lo[IDX_W-1:0];
        w_ra_b      = r_hi[IDX_W-1:0];

        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.action)
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_APPEND: begin
                            if (r_count < CNT_W'(MAX_ELEMENTS)) begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_res.result_kind = KIND_FULL;
                                n_res.found       = 1'b0;
                                n_state           = S_EMIT;
                            end
                        end
                        ACT_SEARCH: begin
                            n_target          = i_req.value;
                            n_lo              = '0;
                            n_hi              = $signed({1'b0, r_count}) - PTR_W'(1);
                            n_res.result_kind = KIND_SEARCH;
                            n_res.found       = 1'b0;
                            n_state           = S_RD1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD1: begin
                if (r_lo > r_hi) begin
                    n_res.found = 1'b0;
                    n_state     = S_EMIT;
                end else begin
                    n_mid   = w_sum[PTR_W:1];
                    n_state = S_RD2;
                end
            end
            S_RD2: begin
                n_vl    = r_rd_a;
                n_vh    = r_rd_b;
                w_ra_a  = r_mid[IDX_W-1:0];
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_RD1;
                if (w_vm == r_target) begin
                    n_res.found = 1'b1;
                    n_state     = S_EMIT;
                end else if (r_vl == w_vm && w_vm == r_vh) begin
                    n_lo = r_lo + PTR_W'(1);
                    n_hi = r_hi - PTR_W'(1);
                end else if (r_vl <= w_vm) begin
                    if (r_vl <= r_target && r_target <= w_vm) begin
                        n_hi = r_mid - PTR_W'(1);
                    end else begin
                        n_lo = r_mid + PTR_W'(1);
                    end
                end else begin
                    if (w_vm <= r_target && r_target <= r_vh) begin
                        n_lo = r_mid + PTR_W'(1);
                    end else begin
                        n_hi = r_mid - PTR_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (w_emit_load) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_vl     <= n_vl;
        r_vh     <= n_vh;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    `RSSD_ASSERT_IMPL(a_write_room, w_we, r_count < CNT_W'(MAX_ELEMENTS), "write when full")
    `RSSD_ASSERT_IMPL(a_eval_bounds, r_state == S_EVAL, r_lo <= r_mid && r_mid <= r_hi, "bad midpoint")
    `RSSD_ASSERT_NEXT(a_emit_loads, w_emit_load, r_out_valid && r_state == S_IDLE, "response lost")
    `RSSD_ASSERT(a_count_max, r_count <= CNT_W'(MAX_ELEMENTS), "count overflow")

endmodule

/* tb/rotated_sorted_search_dup_core_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rotated sorted search core testbench
// Drives clear, append and search requests through the request channel and
// checks every response against a behavioral copy of the element store and
// its search, under random idling on both sides and a long response hold.
// ---------------------------------------------------------------------------

module rotated_sorted_search_dup_core_test;

    import rssd_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_stall;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_stall = 1'b0;
    t_rsp o_rsp;

    t_req req_queue[$];
    t_rsp answers_due[$];

    logic signed [DATA_W-1:0] shadow_store [MAX_ELEMENTS];
    int unsigned shadow_count = 0;

    int req_idle_pct    = 12;
    int rsp_idle_pct    = 56;
    int stim_items      = 0;
    int requests_taken  = 0;
    int searches_taken  = 0;
    int full_rejects    = 0;
    int answers_checked = 0;
    int error_count     = 0;
    int hold_left       = 0;
    bit long_hold_done  = 1'b0;

    rotated_sorted_search_dup_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit rotated_lookup(logic signed [DATA_W-1:0] target);
        int lo;
        int hi;
        int mid;
        logic signed [DATA_W-1:0] vl;
        logic signed [DATA_W-1:0] vm;
        logic signed [DATA_W-1:0] vh;
        lo = 0;
        hi = int'(shadow_count) - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            vl  = shadow_store[lo];
            vm  = shadow_store[mid];
            vh  = shadow_store[hi];
            if (vm == target) begin
                return 1'b1;
            end
            if (vl == vm && vm == vh) begin
                lo++;
                hi--;
            end else if (vl <= vm) begin
                if (vl <= target && target <= vm) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end else begin
                if (vm <= target && target <= vh) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void apply_to_store(t_req r);
        t_rsp answer;
        answer = '0;
        case (r.action)
            ACT_CLEAR: begin
                shadow_count = 0;
            end
            ACT_APPEND: begin
                if (shadow_count >= MAX_ELEMENTS) begin
                    answer.result_kind = KIND_FULL;
                    answer.found       = 1'b0;
                    answers_due.push_back(answer);
                    full_rejects++;
                end else begin
                    shadow_store[shadow_count] = r.value;
                    shadow_count++;
                end
            end
            ACT_SEARCH: begin
                answer.result_kind = KIND_SEARCH;
                answer.found       = rotated_lookup(r.value);
                answers_due.push_back(answer);
                searches_taken++;
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            i_req       <= '0;
        end else begin
            if (i_req_valid && !o_req_stall) begin
                apply_to_store(i_req);
                requests_taken++;
            end
            if (!i_req_valid || !o_req_stall) begin
                if (req_queue.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
                    i_req       <= req_queue.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                if (answers_due.size() == 0) begin
                    $error("response with none expected: result_kind %0d found %0d",
                           o_rsp.result_kind, o_rsp.found);
                    error_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (o_rsp.result_kind !== want.result_kind) begin
                        $error("result_kind: expected %0d, actual %0d",
                               want.result_kind, o_rsp.result_kind);
                        error_count++;
                    end
                    if (o_rsp.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, o_rsp.found);
                        error_count++;
                    end
                    answers_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!long_hold_done && answers_checked >= 20) begin
                hold_left      = 600;
                long_hold_done = 1'b1;
            end
            i_rsp_stall <= (hold_left > 0) || ($urandom_range(99) < rsp_idle_pct);
        end
    end

    task automatic push_req(logic [1:0] action, logic signed [DATA_W-1:0] value);
        t_req r;
        r.action = action;
        r.value  = value;
        req_queue.push_back(r);
        if (action != ACT_RESERVED) begin
            stim_items++;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(int spread,
                                                            logic signed [DATA_W-1:0] base);
        logic signed [DATA_W-1:0] corners [7];
        corners = '{WORD_MIN, WORD_MIN + 1, -1, 0, 1, WORD_MAX - 1, WORD_MAX};
        case (spread)
            0:       return $signed($urandom_range(6)) - 3;
            1:       return $urandom;
            2:       return corners[$urandom_range(6)];
            default: return base + $signed($urandom_range(20));
        endcase
    endfunction

    task automatic queue_run(int n_elems, int n_searches, bit do_clear, int forced_spread);
        logic signed [DATA_W-1:0] vals[$];
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] tgt;
        int spread;
        int rot;
        bit unsorted;
        spread   = (forced_spread >= 0) ? forced_spread : $urandom_range(3);
        base     = $urandom;
        unsorted = ($urandom_range(7) == 0);
        for (int i = 0; i < n_elems; i++) begin
            vals.push_back(pick_value(spread, base));
        end
        if (!unsorted) begin
            vals.sort();
            rot = (n_elems > 1) ? $urandom_range(n_elems - 1) : 0;
            repeat (rot) vals.push_back(vals.pop_front());
        end
        if (do_clear) begin
            push_req(ACT_CLEAR, $urandom);
        end
        foreach (vals[i]) begin
            push_req(ACT_APPEND, vals[i]);
            if ($urandom_range(15) == 0) begin
                push_req(ACT_RESERVED, $urandom);
            end
            if ($urandom_range(9) == 0) begin
                push_req(ACT_SEARCH, pick_value(spread, base));
            end
        end
        repeat (n_searches) begin
            case ($urandom_range(3))
                0:       tgt = (vals.size() > 0) ? vals[$urandom_range(vals.size() - 1)]
                                                 : pick_value(spread, base);
                1:       tgt = ((vals.size() > 0) ? vals[$urandom_range(vals.size() - 1)]
                                                  : base) + ($urandom_range(1) ? 1 : -1);
                2:       tgt = pick_value(spread, base);
                default: tgt = $urandom;
            endcase
            push_req(ACT_SEARCH, tgt);
        end
    endtask

    task automatic wait_drained();
        while (req_queue.size() != 0 || i_req_valid || answers_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic queue_random_until(int goal);
        int n;
        while (stim_items < goal) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 12);
            queue_run(n, $urandom_range(1, 6), $urandom_range(4) != 0, -1);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_req(ACT_SEARCH, 0);
        push_req(ACT_RESERVED, WORD_MAX);
        push_req(ACT_APPEND, WORD_MAX);
        push_req(ACT_APPEND, WORD_MAX);
        push_req(ACT_APPEND, WORD_MIN);
        push_req(ACT_APPEND, -3);
        push_req(ACT_APPEND, 0);
        push_req(ACT_APPEND, 0);
        push_req(ACT_APPEND, 0);
        push_req(ACT_SEARCH, WORD_MIN);
        push_req(ACT_SEARCH, WORD_MAX);
        push_req(ACT_SEARCH, 0);
        push_req(ACT_SEARCH, 1);
        push_req(ACT_SEARCH, -1);
        push_req(ACT_CLEAR, WORD_MIN);
        push_req(ACT_SEARCH, 0);
        push_req(ACT_APPEND, 1);
        push_req(ACT_APPEND, 1);
        push_req(ACT_APPEND, 1);
        push_req(ACT_APPEND, 2);
        push_req(ACT_APPEND, 1);
        push_req(ACT_SEARCH, 2);
        push_req(ACT_SEARCH, 3);
        wait_drained();

        queue_random_until(130);
        wait_drained();

        req_idle_pct = 56;
        rsp_idle_pct = 12;
        queue_random_until(250);
        wait_drained();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        queue_run(MAX_ELEMENTS, 6, 1'b1, 0);
        repeat (3) push_req(ACT_APPEND, $urandom);
        push_req(ACT_SEARCH, 3);
        push_req(ACT_SEARCH, $urandom);
        queue_random_until(1400);
        wait_drained();

        repeat (2000) @(posedge i_clk);
        $display("Covered %0d requests: %0d searches and %0d appends to a full store.",
                 requests_taken, searches_taken, full_rejects);
        $display("Checked %0d responses across three idling mixes and a long response hold.",
                 answers_checked);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
